FILE: rtl/core/ngc_pkg.sv
// ----------------------------------------------------------------------------
// ngc_pkg
// Shared types, constants and character helpers for the GGA sentence checker.
// ----------------------------------------------------------------------------
package ngc_pkg;

  // Default saturation point of the comma counter.
  localparam int FIELD_INDEX_MAX_DEF = 15;

  // Channel widths.
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 5;
  localparam int FIELD_NUM_W  = 4;

  // Header length and position counter width.
  localparam int          HEADER_LEN = 6;
  localparam int          POS_W      = 3;
  localparam logic [POS_W-1:0] POS_DONE = POS_W'(HEADER_LEN);

  // Characters with a special meaning in a sentence.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Digit count at which the received checksum is complete.
  localparam logic [1:0] DIGITS_FULL = 2'd2;

  // One accepted input beat.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } ngc_beat_t;

  // One result beat, before packing onto the output channel.
  typedef struct packed {
    logic [7:0]             out_byte;
    logic [FIELD_NUM_W-1:0] field_number;
    logic                   is_field_char;
    logic                   sentence_done;
    logic                   header_valid;
    logic                   checksum_pass;
    logic [7:0]             computed_checksum;
    logic [7:0]             received_checksum;
    logic [1:0]             received_digit_count;
  } ngc_result_t;

  // Expected header character at a given position.
  function automatic logic [7:0] header_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24; // '$'
      3'd1:    c = 8'h47; // 'G'
      3'd2:    c = 8'h50; // 'P'
      3'd3:    c = 8'h47; // 'G'
      3'd4:    c = 8'h47; // 'G'
      3'd5:    c = 8'h41; // 'A'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // True for '0'..'9', 'A'..'F' and 'a'..'f'.
  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  // True for the lowercase hex letters.
  function automatic logic is_lower_hex(input logic [7:0] b);
    return b inside {[8'h61:8'h66]};
  endfunction

  // Nibble value of a hex digit; meaningless for other bytes.
  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [3:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = b[3:0];
    end else begin
      v = 4'(b[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/ngc_in_reg.sv
// ----------------------------------------------------------------------------
// ngc_in_reg
// Input register: captures one sentence beat and holds it until the core
// moves it on to the result register.
// ----------------------------------------------------------------------------
module ngc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ngc_pkg::ngc_beat_t in_beat,
  input  logic              advance,
  output logic              hold_valid,
  output ngc_pkg::ngc_beat_t hold_beat
);
  import ngc_pkg::*;

  logic      valid_r, valid_nxt;
  ngc_beat_t beat_r;

  // The register frees up in the same cycle it hands its beat on.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

endmodule

FILE: rtl/core/ngc_core.sv
// ----------------------------------------------------------------------------
// ngc_core
// Sentence state and per-byte evaluation: header match, checksum XOR,
// received digit collection and comma-delimited field numbering.
// ----------------------------------------------------------------------------
module ngc_core #(
  parameter int FIELD_INDEX_MAX = ngc_pkg::FIELD_INDEX_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  ngc_pkg::ngc_beat_t  beat,
  output ngc_pkg::ngc_result_t result
);
  import ngc_pkg::*;

  localparam int COMMA_W = $clog2(FIELD_INDEX_MAX + 1);
  localparam logic [COMMA_W-1:0] COMMA_MAX = COMMA_W'(FIELD_INDEX_MAX);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               match_r, match_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic               star_r, star_nxt;
  logic [1:0]         dcnt_r, dcnt_nxt;
  logic [7:0]         rval_r, rval_nxt;
  logic               lower_r, lower_nxt;
  logic [COMMA_W-1:0] comma_r, comma_nxt;

  logic [7:0] b;
  logic       hdr_done;
  logic       hv;

  assign b        = beat.data;
  assign hdr_done = (pos_r >= POS_DONE) && match_r;

  // Next sentence state for this byte.
  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    xor_nxt   = xor_r;
    star_nxt  = star_r;
    dcnt_nxt  = dcnt_r;
    rval_nxt  = rval_r;
    lower_nxt = lower_r;
    comma_nxt = comma_r;

    // Header comparison over the first six bytes.
    if (pos_r < POS_DONE) begin
      if (b != header_char(pos_r)) begin
        match_nxt = 1'b0;
      end
      pos_nxt = POS_W'(pos_r + 1'b1);
    end

    // XOR span up to the first star, then checksum digits after it.
    if (!star_r) begin
      if (b == CHAR_STAR) begin
        star_nxt = 1'b1;
      end else if (pos_r != '0 && b != CHAR_DOLLAR) begin
        xor_nxt = xor_r ^ b;
      end
    end else if (b != CHAR_STAR && dcnt_r < DIGITS_FULL && is_hex(b)) begin
      rval_nxt = {rval_r[3:0], hex_nibble(b)};
      dcnt_nxt = 2'(dcnt_r + 1'b1);
      if (is_lower_hex(b)) begin
        lower_nxt = 1'b1;
      end
    end

    // Field numbering, saturating.
    if (b == CHAR_COMMA && comma_r < COMMA_MAX) begin
      comma_nxt = COMMA_W'(comma_r + 1'b1);
    end
  end

  // Result for this byte; verdict fields only on the last byte.
  assign hv = (pos_nxt >= POS_DONE) && match_nxt;

  always_comb begin
    result                      = '0;
    result.out_byte             = b;
    result.field_number         = comma_r[FIELD_NUM_W-1:0];
    result.is_field_char        = hdr_done && (comma_r != '0) && !star_r &&
                                  (b != CHAR_STAR) && (b != CHAR_COMMA);
    result.sentence_done        = beat.last;
    if (beat.last) begin
      result.header_valid         = hv;
      result.checksum_pass        = hv && (dcnt_nxt == DIGITS_FULL) && !lower_nxt &&
                                    (rval_nxt == xor_nxt);
      result.computed_checksum    = xor_nxt;
      result.received_checksum    = rval_nxt;
      result.received_digit_count = dcnt_nxt;
    end
  end

  // State registers; the last byte of a sentence clears them.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && beat.last)) begin
      pos_r   <= '0;
      match_r <= 1'b1;
      xor_r   <= '0;
      star_r  <= 1'b0;
      dcnt_r  <= '0;
      rval_r  <= '0;
      lower_r <= 1'b0;
      comma_r <= '0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      xor_r   <= xor_nxt;
      star_r  <= star_nxt;
      dcnt_r  <= dcnt_nxt;
      rval_r  <= rval_nxt;
      lower_r <= lower_nxt;
      comma_r <= comma_nxt;
    end
  end

endmodule

FILE: rtl/core/ngc_out_reg.sv
// ----------------------------------------------------------------------------
// ngc_out_reg
// Result register: holds one result beat until the downstream side takes it,
// and tells the core when a new beat may move in.
// ----------------------------------------------------------------------------
module ngc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 src_valid,
  output logic                 advance,
  input  ngc_pkg::ngc_result_t src_result,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ngc_pkg::ngc_result_t out_result
);
  import ngc_pkg::*;

  logic        valid_r, valid_nxt;
  ngc_result_t result_r;

  // A beat moves in when the register is empty or being drained.
  assign advance = src_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= src_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: rtl/core/nmea_gga_sentence_checker.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_checker
// Checks GGA sentences byte by byte and reports header and checksum verdicts.
// ----------------------------------------------------------------------------
// The block takes one sentence byte per beat and returns one result beat for
// each, at a rate of one beat per clock cycle when neither side stalls. An
// accepted byte passes an input register, one short stage of compare and XOR
// logic that also updates the sentence state, and a result register. Each
// result carries the byte, its comma-delimited field number and a field-data
// flag; the beat marked with tlast also carries the verdict (header, computed
// and received checksum, digit count and pass), after which the sentence
// state clears. in_tready depends combinationally on out_tready.
module nmea_gga_sentence_checker #(
  parameter int FIELD_INDEX_MAX = ngc_pkg::FIELD_INDEX_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] in_byte
  input  logic [ngc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte, [8] header_valid, [9] checksum_pass,
  // [17:10] computed_checksum, [25:18] received_checksum,
  // [27:26] received_digit_count, [31:28] zero
  output logic [ngc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [3:0] field_number, [4] is_field_char
  output logic [ngc_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);
  import ngc_pkg::*;

  ngc_beat_t   in_beat;
  ngc_beat_t   hold_beat;
  logic        hold_valid;
  logic        advance;
  ngc_result_t core_result;
  ngc_result_t out_result;

  assign in_beat.data = in_tdata;
  assign in_beat.last = in_tlast;

  ngc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  ngc_core #(
    .FIELD_INDEX_MAX (FIELD_INDEX_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .beat    (hold_beat),
    .result  (core_result)
  );

  ngc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (hold_valid),
    .advance    (advance),
    .src_result (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the result beat onto the output channel.
  assign out_tdata = {4'b0000,
                      out_result.received_digit_count,
                      out_result.received_checksum,
                      out_result.computed_checksum,
                      out_result.checksum_pass,
                      out_result.header_valid,
                      out_result.out_byte};
  assign out_tuser = {out_result.is_field_char, out_result.field_number};
  assign out_tlast = out_result.sentence_done;

endmodule

FILE: rtl/core/ngc_checker.sv
// ----------------------------------------------------------------------------
// ngc_checker
// Port-level checks on the result channel of the GGA sentence checker.
// ----------------------------------------------------------------------------
module ngc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ngc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ngc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import ngc_pkg::*;

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Verdict fields are zero on every beat but the last of a sentence.
  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[27:8] == 20'd0)
    else $error("verdict fields set on a non-final beat");

  // A pass needs a valid header, two digits and matching checksums.
  a_pass_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |->
      out_tdata[8] && out_tdata[27:26] == DIGITS_FULL &&
      out_tdata[17:10] == out_tdata[25:18])
    else $error("checksum pass without matching evidence");

  // Field data is never a delimiter and never in the sentence type field.
  a_field_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |->
      out_tdata[7:0] != CHAR_COMMA && out_tdata[7:0] != CHAR_STAR &&
      out_tuser[3:0] != 4'd0)
    else $error("delimiter or header byte flagged as field data");

endmodule

bind nmea_gga_sentence_checker ngc_checker u_ngc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
